// ===== hw/rtl/frame_sequence_average_unit_macros.svh =====
// assertion helpers shared by the frame averaging block
// each use expects clk_i and rst_ni in scope
`ifndef FRAME_SEQUENCE_AVERAGE_UNIT_MACROS_SVH
`define FRAME_SEQUENCE_AVERAGE_UNIT_MACROS_SVH

// same-cycle implication
`define FSAU_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSAU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fsau_pkg.sv =====
package fsau_pkg;

  // region and sequence bounds
  localparam int MaxRows   = 512;
  localparam int MaxCols   = 512;
  localparam int MaxFrames = 256;

  // register widths
  localparam int RowsW    = 10;
  localparam int ColsW    = 10;
  localparam int FramesW  = 9;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;

  // counter widths
  localparam int RowIdxW   = $clog2(MaxRows);
  localparam int ColIdxW   = $clog2(MaxCols);
  localparam int FrameIdxW = $clog2(MaxFrames);

  // accumulator store
  localparam int StoreDepth = MaxRows * MaxCols;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int SumW       = 16;
  localparam int PixW       = 8;

  // divider layout: one quotient bit per step
  localparam int StepsPerStage = 2;
  localparam int DivStages     = PixW / StepsPerStage;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRows   = 2'd0,
    CfgCols   = 2'd1,
    CfgFrames = 2'd2
  } cfg_idx_e;

  // where a pixel sits in the sequence
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic             is_first;
    logic             is_final;
    logic             is_last;
  } pos_t;

  // pixel with its position, between the sequencer and the accumulator
  typedef struct packed {
    logic            valid;
    logic [PixW-1:0] pix;
    pos_t            pos;
  } stage_t;

  // write-back stage, between the accumulator and the divider
  typedef struct packed {
    logic             valid;
    logic [SumW-1:0]  total;
    logic [AddrW-1:0] addr;
    logic             wr;
    logic             is_final;
    logic             is_last;
  } wb_t;

endpackage

// ===== hw/rtl/fsau_ram.sv =====
module fsau_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port, read returns old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fsau_seq.sv =====
module fsau_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [fsau_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fsau_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          adv_i,
  input  logic                          in_valid_i,
  input  logic [fsau_pkg::PixW-1:0]     pix_i,
  output logic [fsau_pkg::FramesW-1:0]  nf_o,
  output fsau_pkg::stage_t              stg_o
);
  import fsau_pkg::*;

  logic [RowsW-1:0]     rows_q, rows_d;
  logic [ColsW-1:0]     cols_q, cols_d;
  logic [FramesW-1:0]   frames_q, frames_d;
  logic                 restart;
  logic [RowsW-1:0]     nr;
  logic [ColsW-1:0]     nc;
  logic [FramesW-1:0]   nf;
  logic [RowIdxW-1:0]   row_q;
  logic [ColIdxW-1:0]   col_q;
  logic [FrameIdxW-1:0] frame_q;
  logic [AddrW-1:0]     addr_q;
  logic                 accept;
  logic                 final_col, final_row, final_frame;
  stage_t               stg_q;

  // register write decode
  always_comb begin
    rows_d   = rows_q;
    cols_d   = cols_q;
    frames_d = frames_q;
    restart  = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgRows: begin
          rows_d  = RowsW'(cfg_data_i);
          restart = 1'b1;
        end
        CfgCols: begin
          cols_d  = ColsW'(cfg_data_i);
          restart = 1'b1;
        end
        CfgFrames: begin
          frames_d = FramesW'(cfg_data_i);
          restart  = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  // zero acts as one, values above the bound saturate
  assign nr = (rows_q == '0) ? RowsW'(1) :
              (rows_q > RowsW'(MaxRows)) ? RowsW'(MaxRows) : rows_q;
  assign nc = (cols_q == '0) ? ColsW'(1) :
              (cols_q > ColsW'(MaxCols)) ? ColsW'(MaxCols) : cols_q;
  assign nf = (frames_q == '0) ? FramesW'(1) :
              (frames_q > FramesW'(MaxFrames)) ? FramesW'(MaxFrames) : frames_q;

  // position of the current pixel
  assign accept      = in_valid_i & adv_i;
  assign final_col   = (ColsW'(col_q) + ColsW'(1)) == nc;
  assign final_row   = (RowsW'(row_q) + RowsW'(1)) == nr;
  assign final_frame = (FramesW'(frame_q) + FramesW'(1)) == nf;

  // registers and raster counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= RowsW'(1);
      cols_q   <= ColsW'(1);
      frames_q <= FramesW'(1);
      row_q    <= '0;
      col_q    <= '0;
      frame_q  <= '0;
      addr_q   <= '0;
    end else begin
      rows_q   <= rows_d;
      cols_q   <= cols_d;
      frames_q <= frames_d;
      if (restart) begin
        row_q   <= '0;
        col_q   <= '0;
        frame_q <= '0;
        addr_q  <= '0;
      end else if (accept) begin
        if (final_col) begin
          col_q <= '0;
          if (final_row) begin
            row_q   <= '0;
            addr_q  <= '0;
            frame_q <= final_frame ? '0 : frame_q + FrameIdxW'(1);
          end else begin
            row_q  <= row_q + RowIdxW'(1);
            addr_q <= addr_q + AddrW'(1);
          end
        end else begin
          col_q  <= col_q + ColIdxW'(1);
          addr_q <= addr_q + AddrW'(1);
        end
      end
    end
  end

  // first pipeline register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= '0;
    end else if (adv_i) begin
      stg_q.valid        <= in_valid_i;
      stg_q.pix          <= pix_i;
      stg_q.pos.addr     <= addr_q;
      stg_q.pos.is_first <= (frame_q == '0);
      stg_q.pos.is_final <= final_frame;
      stg_q.pos.is_last  <= final_row & final_col;
    end
  end

  assign nf_o  = nf;
  assign stg_o = stg_q;

endmodule

// ===== hw/rtl/fsau_acc.sv =====
module fsau_acc (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  fsau_pkg::stage_t stg_i,
  output fsau_pkg::wb_t    wb_o
);
  import fsau_pkg::*;

  stage_t          s2_q;
  wb_t             wb_q;
  logic [SumW-1:0] rdata;
  logic            fwd_hit;
  logic [SumW-1:0] base;
  logic [SumW-1:0] sum;
  logic            we;

  // per-pixel accumulator store
  fsau_ram #(
    .Width (SumW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s2_q.pos.addr),
    .wdata_i (sum),
    .re_i    (adv_i & stg_i.valid),
    .raddr_i (stg_i.pos.addr),
    .rdata_o (rdata)
  );

  // the item ahead wrote on the same edge this one read
  assign fwd_hit = wb_q.valid & wb_q.wr & (wb_q.addr == s2_q.pos.addr);

  // add the pixel to the stored or forwarded sum
  assign base = s2_q.pos.is_first ? '0 : (fwd_hit ? wb_q.total : rdata);
  assign sum  = base + SumW'(s2_q.pix);
  assign we   = adv_i & s2_q.valid & ~s2_q.pos.is_final;

  // read-data stage and write-back stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
      wb_q <= '0;
    end else if (adv_i) begin
      s2_q          <= stg_i;
      wb_q.valid    <= s2_q.valid;
      wb_q.total    <= sum;
      wb_q.addr     <= s2_q.pos.addr;
      wb_q.wr       <= ~s2_q.pos.is_final;
      wb_q.is_final <= s2_q.pos.is_final;
      wb_q.is_last  <= s2_q.pos.is_last;
    end
  end

  assign wb_o = wb_q;

endmodule

// ===== hw/rtl/fsau_div.sv =====
module fsau_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic [fsau_pkg::FramesW-1:0] nf_i,
  input  fsau_pkg::wb_t                wb_i,
  output logic                         valid_o,
  output logic [fsau_pkg::PixW-1:0]    quo_o,
  output logic                         last_o
);
  import fsau_pkg::*;

  typedef struct packed {
    logic            valid;
    logic [SumW-1:0] rem;
    logic [PixW-1:0] quo;
    logic            last;
  } div_t;

  div_t stg_in [DivStages];
  div_t stg_d  [DivStages];
  div_t stg_q  [DivStages];

  // only final-frame sums produce a result
  always_comb begin
    stg_in[0].valid = wb_i.valid & wb_i.is_final;
    stg_in[0].rem   = wb_i.total;
    stg_in[0].quo   = '0;
    stg_in[0].last  = wb_i.is_last;
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign stg_in[k] = stg_q[k-1];
    end

    // restoring division, two quotient bits per stage
    always_comb begin : p_step
      logic [SumW:0] trial;
      logic [SumW:0] rem;
      stg_d[k] = stg_in[k];
      rem      = {1'b0, stg_in[k].rem};
      for (int j = 0; j < StepsPerStage; j++) begin
        trial = {(SumW + 1 - FramesW)'(0), nf_i} << (PixW - 1 - (k * StepsPerStage + j));
        if (rem >= trial) begin
          rem = rem - trial;
          stg_d[k].quo[PixW - 1 - (k * StepsPerStage + j)] = 1'b1;
        end
      end
      stg_d[k].rem = rem[SumW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_q[k] <= '0;
      end else if (adv_i) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // last stage is the output register
  assign valid_o = stg_q[DivStages-1].valid;
  assign quo_o   = stg_q[DivStages-1].quo;
  assign last_o  = stg_q[DivStages-1].last;

endmodule

// ===== hw/rtl/frame_sequence_average_unit.sv =====
// Temporal frame averaging of 8-bit pixels. Pixels of the region arrive on the
// slave stream in raster order, frame after frame; the first frame loads a
// 16-bit per-pixel accumulator, middle frames add to it, and during the final
// frame each pixel's sum is divided by the frame count (truncating) and sent
// on the master stream, with tlast on the final pixel of the image. Earlier
// frames produce no output. One pixel is taken every clock cycle; each pixel
// passes the position register that takes the transfer, then the accumulator
// read, the add and write-back, and four divider stages of two quotient bits
// each. Back-pressure stalls the whole pipeline. The configuration port is
// always ready; any write to rows, cols or frames restarts the sequence at the
// first pixel of the first frame. No clearing pass is needed after reset,
// since every accumulator entry is written in the first frame before it is
// read.
`include "frame_sequence_average_unit_macros.svh"

module frame_sequence_average_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fsau_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fsau_pkg::CfgDataW-1:0] cfg_data_i,
  // pixel stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] pixel
  // averaged stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [7:0] avg_pixel
  output logic                          m_axis_tlast
);
  import fsau_pkg::*;

  logic               adv;
  logic [FramesW-1:0] nf;
  stage_t             s1;
  wb_t                wb;

  // whole pipeline moves when the output register is free or drained
  assign adv           = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  fsau_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .adv_i       (adv),
    .in_valid_i  (s_axis_tvalid),
    .pix_i       (s_axis_tdata),
    .nf_o        (nf),
    .stg_o       (s1)
  );

  fsau_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .stg_i  (s1),
    .wb_o   (wb)
  );

  fsau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .nf_i    (nf),
    .wb_i    (wb),
    .valid_o (m_axis_tvalid),
    .quo_o   (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

  // a single-frame run starts and ends its frame on every pixel
  `FSAU_ASSERT_IMPL(a_single_frame, s1.valid && (nf == FramesW'(1)), s1.pos.is_first && s1.pos.is_final, "single-frame pixel not marked first and final")
  // a single-frame run never touches the store
  `FSAU_ASSERT_IMPL(a_no_store_write, wb.valid && wb.wr, nf != FramesW'(1), "accumulator written in a single-frame run")
  // a stall holds the item in the first stage
  `FSAU_ASSERT_NEXT(a_stall_holds, !adv && s1.valid, s1.valid && $stable(s1.pos.addr), "first stage item lost during stall")

endmodule
